FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DATA_WIDTH = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                         command;
    logic signed [DATA_WIDTH-1:0] value;
  } spq_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] popped;
    logic [1:0]                   status;
  } spq_resp_t;

  typedef struct packed {
    logic                         active;
    logic                         placed;
    logic signed [DATA_WIDTH-1:0] data;
  } spq_wave_t;

endpackage

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One storage cell of the queue. An insert wave enters from the left neighbor,
// drops its value here at the first strictly worse entry (or at the end of the
// list) and carries the displaced entry onward. A pop shifts the right
// neighbor's entry in.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int OCC_W = 5,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         max_first,
  input  logic                         pop,
  input  logic [OCC_W-1:0]             fill,
  input  logic signed [DATA_WIDTH-1:0] right_entry,
  input  spq_wave_t                    wave_in,
  output logic signed [DATA_WIDTH-1:0] entry,
  output spq_wave_t                    wave_out
);

  logic signed [DATA_WIDTH-1:0] entry_r, entry_nxt;
  spq_wave_t                    wave_r, wave_nxt;
  logic                         last;
  logic                         worse;
  logic                         take;

  assign last  = (fill == OCC_W'(INDEX));
  assign worse = max_first ? (entry_r < wave_in.data) : (entry_r > wave_in.data);
  assign take  = wave_in.active && (wave_in.placed || last || worse);

  always_comb begin
    entry_nxt = entry_r;
    if (pop) begin
      entry_nxt = right_entry;
    end else if (take) begin
      entry_nxt = wave_in.data;
    end
    wave_nxt.active = wave_in.active && !last;
    wave_nxt.placed = wave_in.placed || take;
    wave_nxt.data   = take ? entry_r : wave_in.data;
  end

  always_ff @(posedge clk) begin
    entry_r     <= entry_nxt;
    wave_r.placed <= wave_nxt.placed;
    wave_r.data   <= wave_nxt.data;
    if (!rst_n) begin
      wave_r.active <= 1'b0;
    end else begin
      wave_r.active <= wave_nxt.active;
    end
  end

  assign entry    = entry_r;
  assign wave_out = wave_r;

endmodule

FILE: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of signed words held as a row of cells in sorted
// order, head in cell 0. Equal values keep their arrival order.
//
// Channel  Direction  Payload      Handshake
// in_      input      spq_req_t    in_valid / in_ready
// out_     output     spq_resp_t   out_valid / out_ready
// cfg_     input      max_first    cfg_valid / cfg_ready
//
// A pop, a pop on an empty queue and an insert into a full queue complete
// without holding off the next request. An accepted insert sends a wave along
// the cell row, one cell per cycle; no request is taken until it reaches the end of the list.
// The result sits in an output register; a stalled output holds the input.
// Reset empties the queue and selects smallest first.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  spq_req_t  in_req,
  output logic      out_valid,
  input  logic      out_ready,
  output spq_resp_t out_resp,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic                         max_first_r;
  logic [OCC_W-1:0]             occ_r, occ_nxt;
  logic [OCC_W-1:0]             fill_r, fill_nxt;
  logic [OCC_W-1:0]             cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  spq_resp_t                    resp_r, resp_nxt;
  spq_wave_t                    launch_r, launch_nxt;
  logic                         accept;
  logic                         pop;
  logic                         is_empty;
  logic                         is_full;

  spq_wave_t                    wave  [CAPACITY+1];
  logic signed [DATA_WIDTH-1:0] entry [CAPACITY];

  assign is_empty  = (occ_r == '0);
  assign is_full   = (occ_r == OCC_W'(CAPACITY));
  assign in_ready  = (cnt_r == '0) && !wave[CAPACITY].active && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign pop       = accept && (in_req.command == CMD_POP) && !is_empty;
  assign cfg_ready = 1'b1;

  assign wave[0] = launch_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] right_entry;
    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = entry[i+1];
    end
    spq_cell #(
      .OCC_W (OCC_W),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .max_first   (max_first_r),
      .pop         (pop),
      .fill        (fill_r),
      .right_entry (right_entry),
      .wave_in     (wave[i]),
      .entry       (entry[i]),
      .wave_out    (wave[i+1])
    );
  end

  always_comb begin
    occ_nxt       = occ_r;
    fill_nxt      = fill_r;
    cnt_nxt       = (cnt_r != '0) ? cnt_r - OCC_W'(1) : cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    resp_nxt      = resp_r;
    launch_nxt    = '{active: 1'b0, placed: 1'b0, data: in_req.value};
    if (accept) begin
      out_valid_nxt   = 1'b1;
      resp_nxt.popped = '0;
      resp_nxt.status = STATUS_OK;
      if (in_req.command == CMD_POP) begin
        if (is_empty) begin
          resp_nxt.popped = '1;
          resp_nxt.status = STATUS_EMPTY;
        end else begin
          resp_nxt.popped = entry[0];
          occ_nxt         = occ_r - OCC_W'(1);
        end
      end else if (is_full) begin
        resp_nxt.status = STATUS_FULL;
      end else begin
        launch_nxt.active = 1'b1;
        fill_nxt          = occ_r;
        cnt_nxt           = occ_r + OCC_W'(1);
        occ_nxt           = occ_r + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    resp_r          <= resp_nxt;
    fill_r          <= fill_nxt;
    launch_r.placed <= launch_nxt.placed;
    launch_r.data   <= launch_nxt.data;
    if (!rst_n) begin
      max_first_r     <= 1'b0;
      occ_r           <= '0;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
      launch_r.active <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_first_r <= cfg_data;
      end
      occ_r           <= occ_nxt;
      cnt_r           <= cnt_nxt;
      out_valid_r     <= out_valid_nxt;
      launch_r.active <= launch_nxt.active;
    end
  end

  assign out_valid = out_valid_r;
  assign out_resp  = resp_r;

endmodule
